// ===== rtl/mlkcc_pkg.sv =====
package mlkcc_pkg;

    // Modulus and rounding terms
    localparam int KQ          = 3329;
    localparam int HALF_Q      = KQ / 2;

    // Field and datapath widths
    localparam int IN_W        = 13;
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 10;
    localparam int COEF_W      = 12;
    localparam int NUM_W       = 22;
    localparam int BUF_W       = 17;
    localparam int FILL_W      = 5;
    localparam int DW          = 4;
    localparam int NRES_W      = 4;
    localparam int MAX_RESULTS = 8;

    // Reciprocal of q: floor(n * RECIP_Q >> RECIP_SHIFT) == floor(n / q) for n < 2^NUM_W
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_W     = 23;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_Q =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(KQ) - 64'd1) / 64'(KQ));

    // Queue depths and polynomial length default
    localparam int MID_DEPTH       = 4;
    localparam int OUT_DEPTH       = 2;
    localparam int POLY_COEFFS_DEF = 256;

    // Width mode codes
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_D1    = 2'd0;
    localparam mode_t MODE_D4    = 2'd1;
    localparam mode_t MODE_D10   = 2'd2;
    localparam mode_t MODE_RESET = MODE_D4;

    // Request codes
    localparam logic REQ_COMPRESS   = 1'b0;
    localparam logic REQ_DECOMPRESS = 1'b1;

    // Classified item handed from front to back
    typedef struct packed {
        logic              is_dcp;
        logic [CODE_W-1:0] data;
    } work_item_t;

    // One result item
    typedef struct packed {
        logic [COEF_W-1:0] out_value;
        logic              last_of_run;
        logic              poly_end;
    } result_t;

    // Back stage: first step of an item, or draining its remaining results
    typedef enum logic {
        PH_ENTRY,
        PH_DRAIN
    } back_phase_t;

    // Compressed width in bits; the unused code acts as 10 bits
    function automatic logic [DW-1:0] coeff_width(input mode_t mode);
        logic [DW-1:0] w;
        case (mode)
            MODE_D1: w = DW'(1);
            MODE_D4: w = DW'(4);
            default: w = DW'(10);
        endcase
        return w;
    endfunction

    function automatic logic [CODE_W-1:0] code_mask(input mode_t mode);
        logic [CODE_W-1:0] m;
        case (mode)
            MODE_D1: m = CODE_W'(10'h001);
            MODE_D4: m = CODE_W'(10'h00f);
            default: m = CODE_W'(10'h3ff);
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/mlkcc_fifo.sv =====
module mlkcc_fifo #(
    parameter int WIDTH = $bits(mlkcc_pkg::work_item_t),
    parameter int DEPTH = mlkcc_pkg::MID_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers with wrap at DEPTH
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (AW+1)'(1);
            2'b01:   count_next = count_reg - (AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/mlkcc_front.sv =====
module mlkcc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mlkcc_pkg::mode_t                      mode,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  req_type,
    input  logic signed [mlkcc_pkg::IN_W-1:0]     in_value,
    output logic                                  q_push,
    output mlkcc_pkg::work_item_t                 q_item,
    input  logic                                  q_full
);

    logic                              s1_valid_reg, s1_valid_next;
    logic                              s1_is_dcp_reg;
    logic [mlkcc_pkg::NUM_W-1:0]       s1_num_reg, s1_num_next;
    logic                              accept;
    logic [mlkcc_pkg::IN_W:0]          v_ext, v_plus_q, v_plus_2q, v_minus_q;
    logic [mlkcc_pkg::COEF_W-1:0]      lifted;
    logic [mlkcc_pkg::NUM_W-1:0]       num;
    logic [mlkcc_pkg::PROD_W-1:0]      prod;
    logic [mlkcc_pkg::CODE_W-1:0]      quot;

    assign full   = s1_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = s1_valid_reg && !q_full;

    // Lift coefficient into [0,q) and form the rounding numerator
    always_comb
    begin
        v_ext     = {in_value[mlkcc_pkg::IN_W-1], in_value};
        v_plus_q  = v_ext + (mlkcc_pkg::IN_W+1)'(mlkcc_pkg::KQ);
        v_plus_2q = v_ext + (mlkcc_pkg::IN_W+1)'(2 * mlkcc_pkg::KQ);
        v_minus_q = v_ext - (mlkcc_pkg::IN_W+1)'(mlkcc_pkg::KQ);
        if (v_ext[mlkcc_pkg::IN_W])
        begin
            lifted = v_plus_q[mlkcc_pkg::IN_W] ? v_plus_2q[mlkcc_pkg::COEF_W-1:0]
                                               : v_plus_q[mlkcc_pkg::COEF_W-1:0];
        end
        else if (v_ext >= (mlkcc_pkg::IN_W+1)'(mlkcc_pkg::KQ))
        begin
            lifted = v_minus_q[mlkcc_pkg::COEF_W-1:0];
        end
        else
        begin
            lifted = v_ext[mlkcc_pkg::COEF_W-1:0];
        end

        case (mode)
            mlkcc_pkg::MODE_D1: num = mlkcc_pkg::NUM_W'({lifted, 1'b0});
            mlkcc_pkg::MODE_D4: num = mlkcc_pkg::NUM_W'({lifted, 4'b0});
            default:            num = mlkcc_pkg::NUM_W'({lifted, 10'b0});
        endcase
        num = num + mlkcc_pkg::NUM_W'(mlkcc_pkg::HALF_Q);

        if (req_type == mlkcc_pkg::REQ_DECOMPRESS)
        begin
            s1_num_next = mlkcc_pkg::NUM_W'(in_value[mlkcc_pkg::BYTE_W-1:0]);
        end
        else
        begin
            s1_num_next = num;
        end
    end

    // Hold stage 1 until the queue takes it
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_is_dcp_reg <= (req_type == mlkcc_pkg::REQ_DECOMPRESS);
            s1_num_reg    <= s1_num_next;
        end
    end

    // Divide by q through the reciprocal and keep d bits
    always_comb
    begin
        prod = mlkcc_pkg::PROD_W'(s1_num_reg) * mlkcc_pkg::PROD_W'(mlkcc_pkg::RECIP_Q);
        quot = prod[mlkcc_pkg::RECIP_SHIFT +: mlkcc_pkg::CODE_W];
        q_item.is_dcp = s1_is_dcp_reg;
        if (s1_is_dcp_reg)
        begin
            q_item.data = mlkcc_pkg::CODE_W'(s1_num_reg[mlkcc_pkg::BYTE_W-1:0]);
        end
        else
        begin
            q_item.data = quot & mlkcc_pkg::code_mask(mode);
        end
    end

endmodule

// ===== rtl/mlkcc_back.sv =====
module mlkcc_back #(
    parameter int POLY_COEFFS = mlkcc_pkg::POLY_COEFFS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mlkcc_pkg::mode_t        mode,
    input  mlkcc_pkg::work_item_t   head,
    input  logic                    head_valid,
    output logic                    head_pop,
    output logic                    res_push,
    output mlkcc_pkg::result_t      res,
    input  logic                    res_full
);

    localparam int CNT_W = $clog2(POLY_COEFFS);

    mlkcc_pkg::back_phase_t           phase_reg, phase_next;
    logic [mlkcc_pkg::BUF_W-1:0]      buf_reg, buf_next;
    logic [mlkcc_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             end_reg, end_next;
    logic [mlkcc_pkg::NRES_W-1:0]     nres_reg, nres_next;

    logic                             active, emit, done;
    logic [mlkcc_pkg::DW-1:0]         d;
    logic [mlkcc_pkg::FILL_W-1:0]     d_f;
    logic [mlkcc_pkg::CODE_W-1:0]     mask;
    logic                             cnt_wrap;
    logic [CNT_W-1:0]                 cnt_inc;
    logic                             entry, pre, merge, stale, w_end;
    logic [mlkcc_pkg::BUF_W-1:0]      w_buf, b0, r_buf;
    logic [mlkcc_pkg::FILL_W-1:0]     w_fill, f0, r_fill;
    logic [mlkcc_pkg::NRES_W-1:0]     n_cur;
    logic [mlkcc_pkg::CODE_W-1:0]     y;
    logic [mlkcc_pkg::NUM_W-1:0]      coef_sum;

    assign d        = mlkcc_pkg::coeff_width(mode);
    assign d_f      = mlkcc_pkg::FILL_W'(d);
    assign mask     = mlkcc_pkg::code_mask(mode);
    assign active   = head_valid && !res_full;
    assign cnt_wrap = (cnt_reg == CNT_W'(POLY_COEFFS - 1));
    assign cnt_inc  = cnt_wrap ? '0 : cnt_reg + CNT_W'(1);
    assign entry    = (phase_reg == mlkcc_pkg::PH_ENTRY);
    assign head_pop = active && done;
    assign res_push = active && emit;

    // One step of the head item: at most one result per cycle
    always_comb
    begin
        phase_next    = phase_reg;
        buf_next      = buf_reg;
        fill_next     = fill_reg;
        cnt_next      = cnt_reg;
        end_next      = end_reg;
        nres_next     = nres_reg;
        emit          = 1'b0;
        done          = 1'b0;
        res.out_value = '0;
        res.last_of_run = 1'b0;
        res.poly_end  = 1'b0;
        pre           = 1'b0;
        merge         = 1'b0;
        stale         = 1'b0;
        w_end         = 1'b0;
        b0            = '0;
        f0            = '0;
        w_buf         = buf_reg;
        w_fill        = fill_reg;
        r_buf         = '0;
        r_fill        = '0;
        n_cur         = '0;
        y             = '0;
        coef_sum      = '0;

        if (!head.is_dcp)
        begin
            // Compress: flush stale bytes, then add the code and emit full bytes
            pre   = entry && (fill_reg >= mlkcc_pkg::FILL_W'(8));
            merge = entry && !pre;
            if (merge)
            begin
                w_buf  = buf_reg | (mlkcc_pkg::BUF_W'(head.data) << fill_reg);
                w_fill = fill_reg + d_f;
                w_end  = cnt_wrap;
            end
            else
            begin
                w_end  = end_reg;
            end
            r_buf  = w_buf >> 8;
            r_fill = w_fill - mlkcc_pkg::FILL_W'(8);

            if (pre)
            begin
                emit = 1'b1;
                res.out_value = mlkcc_pkg::COEF_W'(buf_reg[7:0]);
                res.last_of_run = (r_fill < mlkcc_pkg::FILL_W'(8)) &&
                                  ((r_fill + d_f) < mlkcc_pkg::FILL_W'(8)) && !cnt_wrap;
                buf_next  = r_buf;
                fill_next = r_fill;
            end
            else
            begin
                if (merge)
                begin
                    cnt_next = cnt_inc;
                    end_next = cnt_wrap;
                end
                if (w_fill >= mlkcc_pkg::FILL_W'(8))
                begin
                    emit = 1'b1;
                    res.out_value = mlkcc_pkg::COEF_W'(w_buf[7:0]);
                    done = (r_fill < mlkcc_pkg::FILL_W'(8)) && !(w_end && (r_fill != '0));
                    res.last_of_run = done;
                    res.poly_end    = done && w_end;
                    buf_next  = (done && w_end) ? '0 : r_buf;
                    fill_next = (done && w_end) ? '0 : r_fill;
                end
                else
                begin
                    done = 1'b1;
                    if (w_end && (w_fill != '0))
                    begin
                        // Pad the partial byte at polynomial end
                        emit = 1'b1;
                        res.out_value   = mlkcc_pkg::COEF_W'(w_buf[7:0]);
                        res.last_of_run = 1'b1;
                        res.poly_end    = 1'b1;
                    end
                    buf_next  = w_end ? '0 : w_buf;
                    fill_next = w_end ? '0 : w_fill;
                end
                phase_next = done ? mlkcc_pkg::PH_ENTRY : mlkcc_pkg::PH_DRAIN;
            end
        end
        else
        begin
            // Decompress: drop stale bits, append the byte, emit a coefficient per d-bit value
            stale = fill_reg >= d_f;
            f0    = stale ? '0 : fill_reg;
            b0    = stale ? '0 : buf_reg;
            if (entry)
            begin
                w_buf  = b0 | (mlkcc_pkg::BUF_W'(head.data[mlkcc_pkg::BYTE_W-1:0]) << f0);
                w_fill = f0 + mlkcc_pkg::FILL_W'(8);
                n_cur  = '0;
            end
            else
            begin
                n_cur  = nres_reg;
            end
            r_buf    = w_buf >> d;
            r_fill   = w_fill - d_f;
            y        = w_buf[mlkcc_pkg::CODE_W-1:0] & mask;
            coef_sum = (mlkcc_pkg::NUM_W'(y) * mlkcc_pkg::NUM_W'(mlkcc_pkg::KQ)) +
                       (mlkcc_pkg::NUM_W'(1) << (d - mlkcc_pkg::DW'(1)));

            if ((w_fill >= d_f) && (n_cur < mlkcc_pkg::NRES_W'(mlkcc_pkg::MAX_RESULTS)))
            begin
                emit = 1'b1;
                res.out_value = mlkcc_pkg::COEF_W'(coef_sum >> d);
                cnt_next = cnt_inc;
                if (cnt_wrap)
                begin
                    // Polynomial complete: discard leftover bits
                    done = 1'b1;
                    res.poly_end = 1'b1;
                    buf_next  = '0;
                    fill_next = '0;
                end
                else
                begin
                    done = (r_fill < d_f) ||
                           (n_cur == mlkcc_pkg::NRES_W'(mlkcc_pkg::MAX_RESULTS - 1));
                    buf_next  = r_buf;
                    fill_next = r_fill;
                end
                res.last_of_run = done;
            end
            else
            begin
                done      = 1'b1;
                buf_next  = w_buf;
                fill_next = w_fill;
            end
            nres_next  = done ? '0 : n_cur + mlkcc_pkg::NRES_W'(1);
            phase_next = done ? mlkcc_pkg::PH_ENTRY : mlkcc_pkg::PH_DRAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mlkcc_pkg::PH_ENTRY;
            buf_reg   <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            end_reg   <= 1'b0;
            nres_reg  <= '0;
        end
        else if (active)
        begin
            phase_reg <= phase_next;
            buf_reg   <= buf_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            end_reg   <= end_next;
            nres_reg  <= nres_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= mlkcc_pkg::FILL_W'(mlkcc_pkg::BUF_W))
        else $error("bit fill exceeds buffer width");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(POLY_COEFFS - 1))
        else $error("coefficient counter out of range");

    a_poly_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.poly_end) |=> (fill_reg == '0 && cnt_reg == '0))
        else $error("state not cleared after polynomial end");

    a_pop_returns_entry: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |=> (phase_reg == mlkcc_pkg::PH_ENTRY && nres_reg == '0))
        else $error("item retired without returning to entry phase");

    a_poly_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.poly_end) |-> (res.last_of_run && head_pop))
        else $error("polynomial end not on the last result of its item");
`endif

endmodule

// ===== rtl/mlkem_coeff_compress_codec_top.sv =====
// An accepted item is registered in stage 1 and goes via the mid queue and back stage into
// the output queue. The back stage gives at most one result per step and stalls while the
// output queue is full; a step may give none (an item with no result, or a coefficient that
// completes no byte after stale bytes). A decompressed byte gives 0 to 8 results by mode.
// Reset (rst_n low, asynchronous) empties both queues, clears the bit buffer, fill and
// coefficient counter, and sets the width mode to 4 bits.
module mlkem_coeff_compress_codec_top #(
    parameter int POLY_COEFFS = mlkcc_pkg::POLY_COEFFS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_wr_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                req_type,
    input  logic signed [mlkcc_pkg::IN_W-1:0]   in_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [mlkcc_pkg::COEF_W-1:0]        out_value,
    output logic                                last_of_run,
    output logic                                poly_end
);

    mlkcc_pkg::mode_t       coeff_bits_mode_reg;
    logic                   mid_push, mid_full, mid_empty, mid_pop;
    mlkcc_pkg::work_item_t  mid_wr_item, mid_head;
    logic                   res_push, res_full;
    mlkcc_pkg::result_t     res_item, out_item;

    // Width mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_bits_mode_reg <= mlkcc_pkg::MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            coeff_bits_mode_reg <= cfg_wr_data;
        end
    end

    mlkcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (coeff_bits_mode_reg),
        .push     (push),
        .full     (full),
        .req_type (req_type),
        .in_value (in_value),
        .q_push   (mid_push),
        .q_item   (mid_wr_item),
        .q_full   (mid_full)
    );

    mlkcc_fifo #(
        .WIDTH ($bits(mlkcc_pkg::work_item_t)),
        .DEPTH (mlkcc_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr_item),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_head),
        .empty   (mid_empty)
    );

    mlkcc_back #(
        .POLY_COEFFS (POLY_COEFFS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (coeff_bits_mode_reg),
        .head       (mid_head),
        .head_valid (!mid_empty),
        .head_pop   (mid_pop),
        .res_push   (res_push),
        .res        (res_item),
        .res_full   (res_full)
    );

    mlkcc_fifo #(
        .WIDTH ($bits(mlkcc_pkg::result_t)),
        .DEPTH (mlkcc_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_item),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_item),
        .empty   (empty)
    );

    assign out_value   = out_item.out_value;
    assign last_of_run = out_item.last_of_run;
    assign poly_end    = out_item.poly_end;

endmodule
